### sv/lrps_pkg.sv
package lrps_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned ErrBits   = CoordBits + 4;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic        [CoordBits-1:0] span_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic        [CoordBits+1:0] inc_no_step_t;
  typedef logic signed [CoordBits+2:0] inc_with_step_t;

  typedef enum logic {
    ReqLoad = 1'b0,
    ReqStep = 1'b1
  } req_type_e;

  // line geometry derived from a load item
  typedef struct packed {
    logic           steep;
    coord_t         major_pos;
    coord_t         minor_pos;
    coord_t         major_end;
    logic           major_dir_neg;
    logic           minor_dir_neg;
    err_t           error_term;
    inc_no_step_t   inc_no_step;
    inc_with_step_t inc_with_step;
    coord_t         final_x;
    coord_t         final_y;
  } line_setup_t;

endpackage

### sv/lrps_setup.sv
module lrps_setup (
  input  lrps_pkg::coord_t      start_x_i,
  input  lrps_pkg::coord_t      start_y_i,
  input  lrps_pkg::coord_t      end_x_i,
  input  lrps_pkg::coord_t      end_y_i,
  output lrps_pkg::line_setup_t setup_o
);
  import lrps_pkg::*;

  coord_t                     ax, ay, bx, by;
  logic signed [CoordBits:0]  dx, dy;
  span_t                      adx, ady;
  span_t                      dmaj, dmin;
  logic signed [CoordBits+2:0] dmaj_s, dmin_s;
  logic                       steep;

  always_comb begin
    // order endpoints left to right, ties keep the given order
    if (start_x_i > end_x_i) begin
      ax = end_x_i;
      ay = end_y_i;
      bx = start_x_i;
      by = start_y_i;
    end else begin
      ax = start_x_i;
      ay = start_y_i;
      bx = end_x_i;
      by = end_y_i;
    end

    dx  = (CoordBits+1)'(bx) - (CoordBits+1)'(ax);
    dy  = (CoordBits+1)'(by) - (CoordBits+1)'(ay);
    adx = dx[CoordBits-1:0];
    ady = dy[CoordBits] ? span_t'(-dy) : span_t'(dy);
    steep = (ady >= adx);

    dmaj   = steep ? ady : adx;
    dmin   = steep ? adx : ady;
    dmaj_s = $signed({3'b000, dmaj});
    dmin_s = $signed({3'b000, dmin});

    setup_o.steep         = steep;
    setup_o.major_pos     = steep ? ay : ax;
    setup_o.minor_pos     = steep ? ax : ay;
    setup_o.major_end     = steep ? by : bx;
    // x never runs backwards after ordering
    setup_o.major_dir_neg = steep && dy[CoordBits];
    setup_o.minor_dir_neg = !steep && dy[CoordBits];
    setup_o.inc_no_step   = {1'b0, dmin, 1'b0};
    setup_o.inc_with_step = (dmin_s - dmaj_s) <<< 1;
    setup_o.error_term    = err_t'(dmin_s <<< 1) - err_t'(dmaj_s);
    setup_o.final_x       = bx;
    setup_o.final_y       = by;
  end

endmodule

### sv/line_raster_point_stepper.sv
// Bresenham line rasterizer, one pixel per step item.
// Input channel (in_valid_i/in_ready_o): req_type_i = load (0) takes the
// start/end coordinates, sets up the line and returns nothing; req_type_i =
// step (1) returns the next pixel of the current line in original axes.
// Pixels run from the left endpoint along the major axis; the final endpoint
// comes last with last_point_o set, and step items after it return nothing.
// A load drops any line in progress.
// Output channel (out_valid_o/out_ready_i) carries point_x_o, point_y_o,
// last_point_o from a single result register.
// A pixel is valid the cycle after its step item is accepted.
// Throughput: one item per cycle unless a waiting result stalls the input; the step update is one add and compare.
// in_ready_o is high whenever the result register is empty or is being
// taken in the same cycle, so a stalled receiver stalls the input only
// while a result is waiting.
// Reset clears the active-line flag and the result valid; no line is
// active after reset.
module line_raster_point_stepper (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             req_type_i,
  input  lrps_pkg::coord_t start_x_i,
  input  lrps_pkg::coord_t start_y_i,
  input  lrps_pkg::coord_t end_x_i,
  input  lrps_pkg::coord_t end_y_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output lrps_pkg::coord_t point_x_o,
  output lrps_pkg::coord_t point_y_o,
  output logic             last_point_o
);
  import lrps_pkg::*;

  line_setup_t    setup;
  logic           accept;

  logic           line_active_q, line_active_d;
  logic           out_valid_q, out_valid_d;
  logic           steep_q, steep_d;
  coord_t         major_pos_q, major_pos_d;
  coord_t         minor_pos_q, minor_pos_d;
  coord_t         major_end_q, major_end_d;
  logic           major_dir_neg_q, major_dir_neg_d;
  logic           minor_dir_neg_q, minor_dir_neg_d;
  err_t           error_term_q, error_term_d;
  inc_no_step_t   inc_no_step_q, inc_no_step_d;
  inc_with_step_t inc_with_step_q, inc_with_step_d;
  coord_t         final_x_q, final_x_d;
  coord_t         final_y_q, final_y_d;
  coord_t         point_x_q, point_x_d;
  coord_t         point_y_q, point_y_d;
  logic           last_point_q, last_point_d;

  lrps_setup u_setup (
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .setup_o   (setup)
  );

  assign in_ready_o   = !out_valid_q || out_ready_i;
  assign accept       = in_valid_i && in_ready_o;
  assign out_valid_o  = out_valid_q;
  assign point_x_o    = point_x_q;
  assign point_y_o    = point_y_q;
  assign last_point_o = last_point_q;

  always_comb begin
    line_active_d   = line_active_q;
    out_valid_d     = out_valid_q && !out_ready_i;
    steep_d         = steep_q;
    major_pos_d     = major_pos_q;
    minor_pos_d     = minor_pos_q;
    major_end_d     = major_end_q;
    major_dir_neg_d = major_dir_neg_q;
    minor_dir_neg_d = minor_dir_neg_q;
    error_term_d    = error_term_q;
    inc_no_step_d   = inc_no_step_q;
    inc_with_step_d = inc_with_step_q;
    final_x_d       = final_x_q;
    final_y_d       = final_y_q;
    point_x_d       = point_x_q;
    point_y_d       = point_y_q;
    last_point_d    = last_point_q;

    if (accept) begin
      if (req_type_i == ReqLoad) begin
        line_active_d   = 1'b1;
        steep_d         = setup.steep;
        major_pos_d     = setup.major_pos;
        minor_pos_d     = setup.minor_pos;
        major_end_d     = setup.major_end;
        major_dir_neg_d = setup.major_dir_neg;
        minor_dir_neg_d = setup.minor_dir_neg;
        error_term_d    = setup.error_term;
        inc_no_step_d   = setup.inc_no_step;
        inc_with_step_d = setup.inc_with_step;
        final_x_d       = setup.final_x;
        final_y_d       = setup.final_y;
      end else if (line_active_q) begin
        out_valid_d = 1'b1;
        if (major_pos_q != major_end_q) begin
          point_x_d    = steep_q ? minor_pos_q : major_pos_q;
          point_y_d    = steep_q ? major_pos_q : minor_pos_q;
          last_point_d = 1'b0;
          if (error_term_q > 0) begin
            error_term_d = error_term_q + err_t'(inc_with_step_q);
            minor_pos_d  = minor_dir_neg_q ? minor_pos_q - coord_t'(1)
                                           : minor_pos_q + coord_t'(1);
          end else begin
            error_term_d = error_term_q + err_t'(inc_no_step_q);
          end
          major_pos_d = major_dir_neg_q ? major_pos_q - coord_t'(1)
                                        : major_pos_q + coord_t'(1);
        end else begin
          point_x_d     = final_x_q;
          point_y_d     = final_y_q;
          last_point_d  = 1'b1;
          line_active_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_active_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      line_active_q <= line_active_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    steep_q         <= steep_d;
    major_pos_q     <= major_pos_d;
    minor_pos_q     <= minor_pos_d;
    major_end_q     <= major_end_d;
    major_dir_neg_q <= major_dir_neg_d;
    minor_dir_neg_q <= minor_dir_neg_d;
    error_term_q    <= error_term_d;
    inc_no_step_q   <= inc_no_step_d;
    inc_with_step_q <= inc_with_step_d;
    final_x_q       <= final_x_d;
    final_y_q       <= final_y_d;
    point_x_q       <= point_x_d;
    point_y_q       <= point_y_d;
    last_point_q    <= last_point_d;
  end

`ifndef SYNTHESIS
  // a waiting endpoint means the line is already closed
  a_last_closes_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_point_q |-> !line_active_q)
    else $error("endpoint pending while line still active");

  // a load gives no result and opens a line
  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqLoad |=> !out_valid_o && line_active_q)
    else $error("load item produced a result or left line inactive");

  // reaching the major end gives the flagged endpoint
  a_end_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_type_i == ReqStep && line_active_q
      && major_pos_q == major_end_q |=> out_valid_o && last_point_o)
    else $error("endpoint not flagged at the end of the line");

  // shallow lines always run in increasing x
  a_shallow_dir: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_active_q && !steep_q |-> !major_dir_neg_q)
    else $error("shallow line stepping in negative x");
`endif

endmodule

### sim/line_raster_point_stepper_tb.sv
`timescale 1ns / 100ps

module line_raster_point_stepper_tb;
  import lrps_pkg::*;

  typedef struct {
    req_type_e kind;
    coord_t    sx;
    coord_t    sy;
    coord_t    ex;
    coord_t    ey;
  } line_req_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  logic   clk_i;
  logic   rst_ni;
  logic   in_valid_i;
  logic   in_ready_o;
  logic   req_type_i;
  coord_t start_x_i;
  coord_t start_y_i;
  coord_t end_x_i;
  coord_t end_y_i;
  logic   out_valid_o;
  logic   out_ready_i;
  coord_t point_x_o;
  coord_t point_y_o;
  logic   last_point_o;

  line_raster_point_stepper u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .point_x_o    (point_x_o),
    .point_y_o    (point_y_o),
    .last_point_o (last_point_o)
  );

  line_req_t pending_reqs[$];
  pixel_t    expected_pixels[$];
  line_req_t send_req;

  int sent_cnt      = 0;
  int in_accept_cnt = 0;
  int out_accept_cnt = 0;
  int seen_out_cnt  = 0;
  int send_gap      = 0;
  int recv_stall    = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  int sender_mode   = 0;
  int receiver_mode = 0;
  int fail_count    = 0;

  // line state tracked alongside the block
  logic           cur_active = 1'b0;
  logic           cur_steep = 1'b0;
  coord_t         cur_major = '0;
  coord_t         cur_minor = '0;
  coord_t         cur_major_end = '0;
  logic           cur_major_neg = 1'b0;
  logic           cur_minor_neg = 1'b0;
  err_t           cur_err = '0;
  inc_no_step_t   cur_inc_flat = '0;
  inc_with_step_t cur_inc_diag = '0;
  coord_t         cur_final_x = '0;
  coord_t         cur_final_y = '0;

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic int mag(input int v);
    return (v < 0) ? -v : v;
  endfunction

  // keep base+delta inside the coordinate range by mirroring the delta
  function automatic int fold(input int base, input int delta);
    int v;
    v = base + delta;
    if (v > 32767 || v < -32768) v = base - delta;
    return v;
  endfunction

  function automatic int draw_wait(input int mode);
    case (mode)
      0: return 0;
      1: return ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 19)) : 0;
      default: return $urandom_range(0, 19);
    endcase
  endfunction

  function automatic void raster_predict(input line_req_t r);
    int     ax, ay, bx, by, t, dmaj, dmin;
    pixel_t px;
    if (r.kind == ReqLoad) begin
      ax = r.sx;
      ay = r.sy;
      bx = r.ex;
      by = r.ey;
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      cur_final_x = coord_t'(bx);
      cur_final_y = coord_t'(by);
      cur_steep = (mag(by - ay) >= mag(bx - ax));
      if (cur_steep) begin
        cur_major = coord_t'(ay);
        cur_minor = coord_t'(ax);
        cur_major_end = coord_t'(by);
        dmaj = by - ay;
        dmin = bx - ax;
      end else begin
        cur_major = coord_t'(ax);
        cur_minor = coord_t'(ay);
        cur_major_end = coord_t'(bx);
        dmaj = bx - ax;
        dmin = by - ay;
      end
      cur_major_neg = (dmaj < 0);
      cur_minor_neg = (dmin < 0);
      dmaj = mag(dmaj);
      dmin = mag(dmin);
      cur_inc_flat = inc_no_step_t'(2 * dmin);
      cur_inc_diag = inc_with_step_t'(2 * dmin - 2 * dmaj);
      cur_err = err_t'(2 * dmin - dmaj);
      cur_active = 1'b1;
    end else if (cur_active) begin
      if (cur_major != cur_major_end) begin
        px.x = cur_steep ? cur_minor : cur_major;
        px.y = cur_steep ? cur_major : cur_minor;
        px.last = 1'b0;
        if (cur_err > 0) begin
          cur_err = cur_err + err_t'(cur_inc_diag);
          cur_minor = cur_minor_neg ? cur_minor - 1'b1 : cur_minor + 1'b1;
        end else begin
          cur_err = cur_err + err_t'(cur_inc_flat);
        end
        cur_major = cur_major_neg ? cur_major - 1'b1 : cur_major + 1'b1;
      end else begin
        px.x = cur_final_x;
        px.y = cur_final_y;
        px.last = 1'b1;
        cur_active = 1'b0;
      end
      expected_pixels = {expected_pixels, px};
    end
  endfunction

  task automatic add_load(input int sx, input int sy, input int ex, input int ey);
    line_req_t r;
    r.kind = ReqLoad;
    r.sx = coord_t'(sx);
    r.sy = coord_t'(sy);
    r.ex = coord_t'(ex);
    r.ey = coord_t'(ey);
    pending_reqs = {pending_reqs, r};
  endtask

  // step items carry random coordinates, which the block must ignore
  task automatic add_steps(input int n);
    line_req_t r;
    for (int i = 0; i < n; i++) begin
      r.kind = ReqStep;
      r.sx = coord_t'($urandom);
      r.sy = coord_t'($urandom);
      r.ex = coord_t'($urandom);
      r.ey = coord_t'($urandom);
      pending_reqs = {pending_reqs, r};
    end
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && sent_cnt == in_accept_cnt) begin
      if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (pending_reqs.size() != 0) begin
        send_req = pending_reqs.pop_front();
        req_type_i <= send_req.kind;
        start_x_i <= send_req.sx;
        start_y_i <= send_req.sy;
        end_x_i <= send_req.ex;
        end_y_i <= send_req.ey;
        in_valid_i <= 1'b1;
        sent_cnt++;
        if (sent_cnt % 40 == 0) sender_mode = $urandom_range(0, 2);
        send_gap = draw_wait(sender_mode);
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result receiver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_accept_cnt != seen_out_cnt) begin
        seen_out_cnt = out_accept_cnt;
        if (seen_out_cnt % 40 == 0) receiver_mode = $urandom_range(0, 2);
        recv_stall = draw_wait(receiver_mode);
      end
      // one long hold-off so the result register fills and the input backs up
      if (!hold_done && in_accept_cnt >= 400) begin
        hold_left = 300;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (recv_stall > 0) begin
        out_ready_i <= 1'b0;
        recv_stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // monitor: checks results, then predicts for the accepted item
  always @(posedge clk_i) begin
    pixel_t    px;
    line_req_t acc_req;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        out_accept_cnt++;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, expected none, actual (%0d,%0d) last %0b",
                   $realtime, point_x_o, point_y_o, last_point_o);
          fail_count++;
        end else begin
          px = expected_pixels.pop_front();
          check_field("point_x", px.x, point_x_o);
          check_field("point_y", px.y, point_y_o);
          check_field("last_point", px.last, last_point_o);
        end
      end
      if (in_valid_i && in_ready_o) begin
        in_accept_cnt++;
        acc_req.kind = req_type_e'(req_type_i);
        acc_req.sx = start_x_i;
        acc_req.sy = start_y_i;
        acc_req.ex = end_x_i;
        acc_req.ey = end_y_i;
        raster_predict(acc_req);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int useful, kind, sx, sy, ex, ey, span, n;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    req_type_i = ReqLoad;
    start_x_i = '0;
    start_y_i = '0;
    end_x_i = '0;
    end_y_i = '0;
    out_ready_i = 1'b0;

    // directed: step with no line, single-point line, extremes, ties in x
    add_steps(1);
    add_load(100, -200, 100, -200);
    add_steps(2);
    add_load(-32768, -32768, 32767, 32767);
    add_steps(2);
    add_load(32767, -32768, -32768, 32767);
    add_steps(2);
    add_load(5, 2, 5, -2);
    add_steps(6);
    add_load(2, 1, -2, 0);
    add_steps(6);

    useful = 0;
    while (useful < 950) begin
      kind = $urandom_range(0, 15);
      sx = int'($urandom_range(0, 65535)) - 32768;
      sy = int'($urandom_range(0, 65535)) - 32768;
      if (kind == 15) begin
        sx = $urandom_range(0, 1) ? 32767 : -32768;
        sy = $urandom_range(0, 1) ? 32767 : -32768;
      end
      ex = fold(sx, int'($urandom_range(0, 48)) - 24);
      ey = fold(sy, int'($urandom_range(0, 48)) - 24);
      if (kind == 14) begin
        ex = sx;
        ey = sy;
      end
      span = (mag(ex - sx) > mag(ey - sy)) ? mag(ex - sx) : mag(ey - sy);
      if (kind == 12) begin
        ex = int'($urandom_range(0, 65535)) - 32768;
        ey = int'($urandom_range(0, 65535)) - 32768;
        n = $urandom_range(1, 30);
        add_load(sx, sy, ex, ey);
        add_steps(n);
        useful += 1 + n;
      end else if (kind == 13) begin
        add_load(sx, sy, ex, ey);
        useful += 1;
      end else if (kind == 10 || kind == 11) begin
        n = $urandom_range(0, span);
        add_load(sx, sy, ex, ey);
        add_steps(n);
        useful += 1 + n;
      end else begin
        add_load(sx, sy, ex, ey);
        add_steps(span + 1);
        useful += span + 2;
        if ($urandom_range(0, 3) == 0) add_steps($urandom_range(1, 2));
      end
    end

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_reqs.size() != 0 || sent_cnt != in_accept_cnt) @(posedge clk_i);
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
sv/lrps_pkg.sv
sv/lrps_setup.sv
sv/line_raster_point_stepper.sv
sim/line_raster_point_stepper_tb.sv
